// File: rtl/lprc_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes and the control bundle that drives each recency cell.
// ----------------------------------------------------------------------------
package lprc_pkg;

	// Number of frames built into the recency chain.
	localparam int FRAMES    = 16;
	// Width of a page number.
	localparam int PAGE_BITS = 16;
	// Index of one cell in the chain.
	localparam int IDX_BITS  = $clog2(FRAMES);
	// A count that can hold FRAMES itself.
	localparam int CNT_BITS  = $clog2(FRAMES + 1);
	// Width of the running fault count.
	localparam int FAULT_BITS = 16;
	// Reset value of the frame limit register.
	localparam logic [CNT_BITS-1:0] LIMIT_RESET = CNT_BITS'(FRAMES);

	// Per-cell control from the top level.
	typedef struct packed {
		logic update;   // a reference is being applied this cycle
		logic valid;    // the cell holds a resident page
		logic in_range; // the cell lies inside the shift window for a miss
	} cell_ctl_t;

endpackage

// File: rtl/lprc_cell.sv
// ----------------------------------------------------------------------------
// LRU recency cell
// Holds one resident page, compares it with the reference key and takes the
// page of its front neighbor when the recency order moves back by one slot.
// ----------------------------------------------------------------------------
module lprc_cell (
	input  logic                           clk,
	input  lprc_pkg::cell_ctl_t            ctl,
	input  logic [lprc_pkg::PAGE_BITS-1:0] key,
	input  logic [lprc_pkg::PAGE_BITS-1:0] prev_page,
	input  logic                           found_in,
	output logic                           found_out,
	output logic [lprc_pkg::PAGE_BITS-1:0] page
);

	logic [lprc_pkg::PAGE_BITS-1:0] page_q;
	logic                           match;
	logic                           shift;

	// A cell moves only while no earlier cell has matched: the matching cell
	// itself still takes its neighbor's page, which closes the gap.
	assign match     = ctl.valid && (page_q == key);
	assign shift     = ctl.update && ctl.in_range && !found_in;
	assign found_out = found_in || match;
	assign page      = page_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			page_q <= prev_page;
		end
	end

endmodule

// File: rtl/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// LRU page replacement core
// Fully associative least-recently-used page tracker built as a chain of
// recency cells, most recent page in cell 0.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Signals                                  Transfer
// reference   in         start, busy, ref_page                    start && !busy
// result      out        result_valid, page_fault, evict_valid,   result_valid
//                        evicted_page, resident_count, fault_total
// config      in         frame_limit_we, frame_limit_wdata        frame_limit_we
//
// In the transfer cycle the page is captured and busy rises. In the next
// cycle every cell compares its page with the key in parallel, the match
// ripples down the chain and the cells shift in place, while the result
// registers load. The result strobe is high in the cycle after that, and
// busy is already low then, so a new reference can start while the result
// is shown. The receiver cannot stall the result.
// Reset clears the occupancy, the fault count and the control flags and sets
// the frame limit to the full chain; the cell contents need no reset since a
// cell at or beyond the occupancy is never compared or reported.
//
module lru_page_replacement_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [15:0]                     ref_page,
	input  logic                            frame_limit_we,
	input  logic [4:0]                      frame_limit_wdata,
	output logic                            result_valid,
	output logic                            page_fault,
	output logic                            evict_valid,
	output logic [15:0]                     evicted_page,
	output logic [4:0]                      resident_count,
	output logic [15:0]                     fault_total
);

	// Control and counting state.
	logic                                   busy_q;
	logic [lprc_pkg::PAGE_BITS-1:0]         page_s1;
	logic [lprc_pkg::CNT_BITS-1:0]          frame_limit_q;
	logic [lprc_pkg::CNT_BITS-1:0]          occupied_q;
	logic [lprc_pkg::FAULT_BITS-1:0]        fault_q;

	// Result registers.
	logic                                   result_valid_q;
	logic                                   page_fault_q;
	logic                                   evict_valid_q;
	logic [lprc_pkg::PAGE_BITS-1:0]         evicted_page_q;
	logic [lprc_pkg::CNT_BITS-1:0]          resident_count_q;
	logic [lprc_pkg::FAULT_BITS-1:0]        fault_total_q;

	// Chain signals.
	lprc_pkg::cell_ctl_t                    cell_ctl  [lprc_pkg::FRAMES];
	logic [lprc_pkg::PAGE_BITS-1:0]         cell_page [lprc_pkg::FRAMES];
	logic [lprc_pkg::PAGE_BITS-1:0]         cell_prev [lprc_pkg::FRAMES];
	logic [lprc_pkg::FRAMES:0]              found_chain;

	logic                                   accept;
	logic [lprc_pkg::CNT_BITS-1:0]          eff_limit;
	logic                                   has_room;
	logic [lprc_pkg::IDX_BITS-1:0]          top_idx;
	logic [lprc_pkg::IDX_BITS-1:0]          last_idx;
	logic                                   hit;
	logic                                   evict;

	assign accept = start && !busy_q;

	// The frame limit in force: zero counts as one frame, anything above the
	// chain length counts as the whole chain.
	always_comb begin
		if (frame_limit_q == '0) begin
			eff_limit = lprc_pkg::CNT_BITS'(1);
		end else if (frame_limit_q > lprc_pkg::CNT_BITS'(lprc_pkg::FRAMES)) begin
			eff_limit = lprc_pkg::CNT_BITS'(lprc_pkg::FRAMES);
		end else begin
			eff_limit = frame_limit_q;
		end
	end

	// When there is room the new page extends the list by one, so the shift
	// window reaches the first free cell; otherwise it ends at the oldest page,
	// which falls off the end. Room implies the occupancy is below the chain
	// length, so it fits the index width. A lowered limit leaves the occupancy
	// where it is, and the oldest resident page is replaced.
	assign has_room = occupied_q < eff_limit;
	assign last_idx = lprc_pkg::IDX_BITS'(occupied_q - lprc_pkg::CNT_BITS'(1));
	assign top_idx  = has_room ? occupied_q[lprc_pkg::IDX_BITS-1:0] : last_idx;

	// A hit never lies beyond the miss window, so the same window serves both
	// cases: the ripple of the match stops the shift just after the hit cell.
	always_comb begin
		for (int i = 0; i < lprc_pkg::FRAMES; i++) begin
			cell_ctl[i].update   = busy_q;
			cell_ctl[i].valid    = lprc_pkg::CNT_BITS'(i) < occupied_q;
			cell_ctl[i].in_range = lprc_pkg::IDX_BITS'(i) <= top_idx;
			cell_prev[i]         = (i == 0) ? page_s1 : cell_page[(i == 0) ? 0 : i - 1];
		end
	end

	assign found_chain[0] = 1'b0;

	for (genvar g = 0; g < lprc_pkg::FRAMES; g++) begin : g_cell
		lprc_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[g]),
			.key       (page_s1),
			.prev_page (cell_prev[g]),
			.found_in  (found_chain[g]),
			.found_out (found_chain[g+1]),
			.page      (cell_page[g])
		);
	end

	assign hit   = found_chain[lprc_pkg::FRAMES];
	assign evict = !hit && !has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			frame_limit_q  <= lprc_pkg::LIMIT_RESET;
			occupied_q     <= '0;
			fault_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= busy_q;
			if (frame_limit_we) begin
				frame_limit_q <= frame_limit_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				if (!hit) begin
					if (has_room) begin
						occupied_q <= occupied_q + lprc_pkg::CNT_BITS'(1);
					end
					if (fault_q != '1) begin
						fault_q <= fault_q + lprc_pkg::FAULT_BITS'(1);
					end
				end
			end
		end
	end

	// Captured key and result payload; these need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= ref_page[lprc_pkg::PAGE_BITS-1:0];
		end
		if (busy_q) begin
			page_fault_q   <= !hit;
			evict_valid_q  <= evict;
			evicted_page_q <= evict ? cell_page[last_idx] : '0;
			if (!hit && has_room) begin
				resident_count_q <= occupied_q + lprc_pkg::CNT_BITS'(1);
			end else begin
				resident_count_q <= occupied_q;
			end
			if (!hit && (fault_q != '1)) begin
				fault_total_q <= fault_q + lprc_pkg::FAULT_BITS'(1);
			end else begin
				fault_total_q <= fault_q;
			end
		end
	end

	assign busy           = busy_q;
	assign result_valid   = result_valid_q;
	assign page_fault     = page_fault_q;
	assign evict_valid    = evict_valid_q;
	assign evicted_page   = evicted_page_q;
	assign resident_count = resident_count_q;
	assign fault_total    = fault_total_q;

	// Busy falls as soon as a reference has been applied to the chain.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held for more than one cycle");

	// A result always follows an applied reference.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $past(busy_q))
		else $error("result strobe without an applied reference");

	// An eviction only happens on a fault.
	a_evict_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && evict_valid_q) |-> page_fault_q)
		else $error("eviction reported on a hit");

	// The reported occupancy matches the tracked occupancy.
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (resident_count_q == occupied_q))
		else $error("resident count disagrees with occupancy");

	// The occupancy never exceeds the chain length.
	a_occupied_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupied_q <= lprc_pkg::CNT_BITS'(lprc_pkg::FRAMES))
		else $error("occupancy beyond the chain length");

endmodule

// File: bench/tb_lru_page_replacement_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement core testbench
// Feeds page references into the core and checks every result against an
// in-bench least-recently-used tracker. The frame limit is rewritten between
// phases while the core is idle, and a closing run without idle cycles keeps
// the core busy back to back.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_core;

	// Kinds of work the driver takes from the stimulus queue.
	typedef enum logic [1:0] {
		REQ_PAGE,    // one page reference
		REQ_LIMIT,   // write the frame limit once the core is idle
		REQ_QUIESCE  // hold off until every outstanding result has come back
	} req_kind_t;

	typedef struct {
		req_kind_t                      kind;
		logic [lprc_pkg::PAGE_BITS-1:0] value;
		bit                             gap_ok;  // random idle bursts allowed before this one
	} req_t;

	// What the core should report for one reference.
	typedef struct packed {
		logic                            page_fault;
		logic                            evict_valid;
		logic [lprc_pkg::PAGE_BITS-1:0]  evicted_page;
		logic [lprc_pkg::CNT_BITS-1:0]   resident_count;
		logic [lprc_pkg::FAULT_BITS-1:0] fault_total;
	} ref_outcome_t;

	localparam int WATCHDOG_LIMIT = 1000;

	// DUT ports. Every input has a known value from time zero.
	logic                            clk               = 1'b0;
	logic                            arst_n            = 1'b0;
	logic                            start             = 1'b0;
	logic                            busy;
	logic [lprc_pkg::PAGE_BITS-1:0]  ref_page          = '0;
	logic                            frame_limit_we    = 1'b0;
	logic [lprc_pkg::CNT_BITS-1:0]   frame_limit_wdata = '0;
	logic                            result_valid;
	logic                            page_fault;
	logic                            evict_valid;
	logic [lprc_pkg::PAGE_BITS-1:0]  evicted_page;
	logic [lprc_pkg::CNT_BITS-1:0]   resident_count;
	logic [lprc_pkg::FAULT_BITS-1:0] fault_total;

	// Stimulus waiting to be driven, and outcomes waiting to be observed.
	req_t         req_q[$];
	ref_outcome_t pending_outcomes[$];

	// The driver owns sent_count; the monitor advances done_count with a
	// nonblocking assignment, so the driver always sees a settled value.
	int unsigned sent_count     = 0;
	int unsigned done_count     = 0;
	int unsigned mismatch_count = 0;
	int unsigned gap_left       = 0;
	int unsigned quiet_cycles   = 0;

	// Shadow of the core's state: resident pages in recency order (slot 0 is
	// the most recent), how many slots are occupied, the saturating fault
	// count and the frame limit register as last written.
	logic [lprc_pkg::PAGE_BITS-1:0]  lru_pages [lprc_pkg::FRAMES];
	int                              lru_used    = 0;
	logic [lprc_pkg::FAULT_BITS-1:0] fault_tally = '0;
	logic [lprc_pkg::CNT_BITS-1:0]   limit_reg   = lprc_pkg::LIMIT_RESET;

	lru_page_replacement_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.ref_page         (ref_page),
		.frame_limit_we   (frame_limit_we),
		.frame_limit_wdata(frame_limit_wdata),
		.result_valid     (result_valid),
		.page_fault       (page_fault),
		.evict_valid      (evict_valid),
		.evicted_page     (evicted_page),
		.resident_count   (resident_count),
		.fault_total      (fault_total)
	);

	always #10 clk = ~clk;

	// Reset is held from time zero and released away from the rising edge.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// Applies one reference to the shadow state and returns what the core
	// must report for it.
	function automatic ref_outcome_t lru_reference(logic [lprc_pkg::PAGE_BITS-1:0] pg);
		ref_outcome_t res;
		int           lim;
		int           hit_at;
		int           top;
		int           i;
		res = '0;
		// A zero limit acts as one frame; anything beyond the chain is clipped.
		lim = limit_reg;
		if (lim < 1) lim = 1;
		if (lim > lprc_pkg::FRAMES) lim = lprc_pkg::FRAMES;
		hit_at = -1;
		for (i = 0; i < lru_used; i++) begin
			if (hit_at < 0 && lru_pages[i] == pg) hit_at = i;
		end
		if (hit_at >= 0) begin
			top = hit_at;
		end else begin
			res.page_fault = 1'b1;
			if (lru_used < lim) begin
				top = lru_used;
				lru_used++;
			end else begin
				// Full, or the limit was lowered under the occupancy: the
				// oldest resident page goes and the count stays where it is.
				res.evict_valid  = 1'b1;
				res.evicted_page = lru_pages[lru_used-1];
				top = lru_used - 1;
			end
			if (fault_tally != '1) fault_tally++;
		end
		if (top >= lprc_pkg::FRAMES) top = lprc_pkg::FRAMES - 1;
		for (i = top; i > 0; i--) lru_pages[i] = lru_pages[i-1];
		lru_pages[0] = pg;
		res.resident_count = lprc_pkg::CNT_BITS'(lru_used);
		res.fault_total    = fault_tally;
		return res;
	endfunction

	function automatic void check_field(string name, logic [63:0] want,
					    logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic add_page(logic [lprc_pkg::PAGE_BITS-1:0] pg, bit gap_ok);
		req_q.push_back('{REQ_PAGE, pg, gap_ok});
	endtask

	task automatic add_limit(logic [lprc_pkg::CNT_BITS-1:0] lim);
		req_q.push_back('{REQ_LIMIT, lprc_pkg::PAGE_BITS'(lim), 1'b1});
	endtask

	// A random reference trace. Most pages come from a working set of span
	// pages above a random base, so hits at every depth mix with misses
	// that evict; some repeat the last page and some are anywhere in the
	// page space. Now and then the sender waits for the core to drain.
	task automatic add_trace(int count, int span, bit gap_ok);
		logic [lprc_pkg::PAGE_BITS-1:0] base;
		logic [lprc_pkg::PAGE_BITS-1:0] pg;
		int                             roll;
		int                             k;
		base = lprc_pkg::PAGE_BITS'($urandom_range(0, 65535));
		pg   = base;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 9);
			if (roll < 7)
				pg = base + lprc_pkg::PAGE_BITS'($urandom_range(0, span - 1));
			else if (roll == 9)
				pg = lprc_pkg::PAGE_BITS'($urandom_range(0, 65535));
			add_page(pg, gap_ok);
			if ($urandom_range(0, 59) == 0)
				req_q.push_back('{REQ_QUIESCE, '0, 1'b1});
		end
	endtask

	// Driver. A reference stays on the port until the core takes it; the
	// outcome is predicted at the edge of the transfer. Frame limit writes and
	// drain points wait until every result already issued has been seen.
	always @(posedge clk) begin : drive
		logic launch;
		logic write_limit;
		req_t head;
		if (!arst_n) begin
			start          <= 1'b0;
			frame_limit_we <= 1'b0;
		end else begin
			launch      = 1'b0;
			write_limit = 1'b0;
			if (start && !busy) begin
				pending_outcomes.push_back(lru_reference(ref_page));
				sent_count++;
			end else if (start) begin
				launch = 1'b1;
			end
			if (!launch) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (req_q.size() > 0) begin
					head = req_q[0];
					case (head.kind)
					REQ_PAGE: begin
						if (head.gap_ok && $urandom_range(0, 4) == 0) begin
							gap_left = $urandom_range(1, 18);
						end else begin
							void'(req_q.pop_front());
							launch = 1'b1;
							ref_page <= head.value;
						end
					end
					REQ_LIMIT: begin
						if (done_count == sent_count) begin
							void'(req_q.pop_front());
							write_limit = 1'b1;
							frame_limit_wdata <= head.value[lprc_pkg::CNT_BITS-1:0];
							limit_reg = head.value[lprc_pkg::CNT_BITS-1:0];
						end
					end
					REQ_QUIESCE: begin
						if (done_count == sent_count) void'(req_q.pop_front());
					end
					default: begin
						void'(req_q.pop_front());
					end
					endcase
				end
			end
			start          <= launch;
			frame_limit_we <= write_limit;
		end
	end

	// Monitor. The strobe lasts one cycle and cannot be held off, so every
	// strobed cycle is one result transfer, compared with the oldest outcome.
	always @(posedge clk) begin : observe
		ref_outcome_t want;
		if (arst_n && result_valid) begin
			if (pending_outcomes.size() == 0) begin
				$error("result transfer with no reference outstanding");
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("page_fault", want.page_fault, page_fault);
				check_field("evict_valid", want.evict_valid, evict_valid);
				check_field("evicted_page", want.evicted_page, evicted_page);
				check_field("resident_count", want.resident_count, resident_count);
				check_field("fault_total", want.fault_total, fault_total);
				done_count <= done_count + 1;
			end
		end
	end

	// Watchdog. Any transfer on any channel restarts the count; a core that
	// stops answering ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || frame_limit_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int i;

		// Directed opening. The first two references run at the reset limit,
		// the extreme pages included, and the second shows that limit lets the
		// set grow past one frame.
		add_page(16'h0000, 1'b1);
		add_page(16'hFFFF, 1'b1);
		add_page(16'h0000, 1'b1);  // hit one slot down
		add_page(16'h0000, 1'b1);  // hit at the front
		// The smallest limit while two pages are resident: nothing is dropped,
		// each miss swaps out the oldest page and the count stays at two.
		add_limit(5'd1);
		add_page(16'h8000, 1'b1);
		add_page(16'h0000, 1'b1);
		add_page(16'h7FFF, 1'b1);
		// A zero limit behaves as a single frame.
		add_limit(5'd0);
		add_page(16'h5555, 1'b1);
		add_page(16'h7FFF, 1'b1);
		add_page(16'hAAAA, 1'b1);
		// The largest encodable limit is clipped to the chain: fill every
		// frame, then hit the oldest page and evict from a full chain.
		add_limit(5'd31);
		for (i = 1; i <= 14; i++) add_page(lprc_pkg::PAGE_BITS'(i), 1'b1);
		add_page(16'h7FFF, 1'b1);
		add_page(16'h1234, 1'b1);
		add_page(16'h0007, 1'b1);

		// Random part. Once sixteen pages are resident they stay resident, so
		// every later limit, however small, works through the lowered-limit
		// path; the traces still hit and evict across the whole chain.
		for (i = 0; i < 11; i++) begin
			case (i)
			0:       add_limit(5'd16);
			1:       add_limit(5'd17);
			2:       add_limit(5'd4);
			3:       add_limit(5'd1);
			4:       add_limit(5'd0);
			5:       add_limit(5'd31);
			6:       add_limit(5'd8);
			default: add_limit(lprc_pkg::CNT_BITS'($urandom_range(0, 31)));
			endcase
			// One phase in four runs without idle bursts.
			add_trace(130, (i % 3 == 0) ? 12 : 22, (i % 4) != 2);
		end

		// Closing run with no idling: a single-frame limit and references
		// from the whole page space miss almost every time.
		add_limit(5'd1);
		for (i = 0; i < 60; i++)
			add_page(lprc_pkg::PAGE_BITS'($urandom_range(0, 65535)), 1'b0);

		// Wait for the last result, then let the clock run on so that any stray
		// strobe would still show before the verdict.
		do @(negedge clk);
		while (req_q.size() != 0 || start || done_count != sent_count);
		repeat (6) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
